>>> sv/fps_pkg.sv
package fps_pkg;

  localparam int PRIO_W = 3;
  localparam int CFG_W  = 21;
  localparam int ID_W   = 4;
  localparam int CNT_W  = 32;

  localparam logic [ID_W-1:0]   ID_IDLE   = 4'd14;
  localparam logic [ID_W-1:0]   ID_NONE   = 4'd15;
  localparam logic [ID_W-1:0]   BEST_INIT = 4'd8;
  localparam logic [CFG_W-1:0]  PRIO_RESET = 21'd80;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_TICK   = 2'd1,
    OP_DELAY  = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MODE_READY   = 2'd0,
    MODE_RUNNING = 2'd1,
    MODE_WAITING = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECR,
    S_SCAN,
    S_APPLY,
    S_DONE
  } state_t;

  typedef struct packed {
    state_t st;
    logic   in_ready;
    logic   out_load;
  } ctrl_t;

endpackage

>>> sv/fps_step.sv
module fps_step (
  input  fps_pkg::mode_t                 mode,
  input  logic [fps_pkg::CNT_W-1:0]      wait_val,
  input  logic [fps_pkg::PRIO_W-1:0]     prio,
  input  logic [fps_pkg::ID_W-1:0]       best,
  output fps_pkg::mode_t                 mode_dec,
  output logic [fps_pkg::CNT_W-1:0]      wait_dec,
  output logic                           better
);
  import fps_pkg::*;

  logic expire;

  assign expire = (wait_val <= CNT_W'(1));

  always_comb begin
    mode_dec = mode;
    wait_dec = wait_val;
    if (mode == MODE_WAITING) begin
      if (expire) begin
        wait_dec = '0;
        mode_dec = MODE_READY;
      end else begin
        wait_dec = wait_val - CNT_W'(1);
      end
    end
  end

  assign better = (mode != MODE_WAITING) && (ID_W'(prio) < best);

endmodule

>>> sv/fps_ctrl.sv
module fps_ctrl #(
  parameter int NUM_TASKS = 3,
  parameter int IW = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_fire,
  input  fps_pkg::op_t    op,
  input  logic            run_valid,
  input  logic            out_free,
  output logic [IW-1:0]   idx,
  output fps_pkg::ctrl_t  ctrl
);
  import fps_pkg::*;

  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_TASKS - 1);

  state_t        st;
  state_t        st_next;
  logic [IW-1:0] idx_next;
  logic          last;

  assign last = (idx == LAST_IDX);

  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= S_IDLE;
      idx <= '0;
    end else begin
      st  <= st_next;
      idx <= idx_next;
    end
  end

  always_comb begin
    st_next  = st;
    idx_next = idx;
    unique case (st)
      S_IDLE: begin
        idx_next = '0;
        if (in_fire) begin
          if (op == OP_TICK) begin
            st_next = S_DECR;
          end else if (op == OP_DELAY && run_valid) begin
            st_next = S_SCAN;
          end else begin
            st_next = S_DONE;
          end
        end
      end
      S_DECR: begin
        if (last) begin
          idx_next = '0;
          st_next  = S_SCAN;
        end else begin
          idx_next = idx + IW'(1);
        end
      end
      S_SCAN: begin
        if (last) begin
          idx_next = '0;
          st_next  = S_APPLY;
        end else begin
          idx_next = idx + IW'(1);
        end
      end
      S_APPLY: st_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          st_next = S_IDLE;
        end
      end
      default: st_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl.st       = st;
    ctrl.in_ready = (st == S_IDLE);
    ctrl.out_load = (st == S_DONE) && out_free;
  end

endmodule

>>> sv/fixed_priority_task_scheduler_unit.sv
// fixed-priority preemptive task scheduler, one shared step unit under a sequencer
// from input transfer to result: start, unused op and rejected delay go straight to done;
// delay: per-task priority scan, apply, done; tick: per-task count down, scan, apply, done;
// a result not taken holds the block; one item at a time, as the shared step unit makes
// the per-task passes (count down on a tick, then a priority scan)
// reset: synchronous active-high rst; all tasks ready, waits zero, none running, ticks zero
module fixed_priority_task_scheduler_unit #(
  parameter int NUM_TASKS = 3
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [fps_pkg::CFG_W-1:0]     cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    op,
  input  logic [fps_pkg::CNT_W-1:0]     delay_ticks,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [fps_pkg::ID_W-1:0]      run_task,
  output logic                          switch_needed,
  output logic [fps_pkg::CNT_W-1:0]     tick_count,
  output logic                          request_error
);
  import fps_pkg::*;

  localparam int IW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam logic [ID_W-1:0] NUM_ID = ID_W'(NUM_TASKS);

  ctrl_t              ctrl;
  logic [IW-1:0]      idx;
  logic               in_fire;
  logic               out_free;
  logic               run_valid;
  op_t                op_in;

  logic [CFG_W-1:0]   task_priorities;
  mode_t              task_mode [NUM_TASKS];
  logic [CNT_W-1:0]   wait_left [NUM_TASKS];
  logic [ID_W-1:0]    running_now;
  logic [CNT_W-1:0]   ticks_seen;
  logic [ID_W-1:0]    best;
  logic [ID_W-1:0]    pick;
  logic               preempt;
  logic               run_was_running;
  logic               sw;
  logic               err;

  mode_t              mode_dec;
  logic [CNT_W-1:0]   wait_dec;
  logic               better;
  logic [PRIO_W-1:0]  prio_cur;
  logic [IW-1:0]      run_idx;
  logic [CNT_W-1:0]   delay_val;

  assign op_in     = op_t'(op);
  assign in_ready  = ctrl.in_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign run_valid = (running_now < NUM_ID);
  assign run_idx   = running_now[IW-1:0];
  assign prio_cur  = task_priorities[int'(idx) * PRIO_W +: PRIO_W];
  assign delay_val = (delay_ticks == '0) ? CNT_W'(1) : delay_ticks;

  fps_ctrl #(
    .NUM_TASKS(NUM_TASKS),
    .IW(IW)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_fire(in_fire),
    .op(op_in),
    .run_valid(run_valid),
    .out_free(out_free),
    .idx(idx),
    .ctrl(ctrl)
  );

  fps_step u_step (
    .mode(task_mode[idx]),
    .wait_val(wait_left[idx]),
    .prio(prio_cur),
    .best(best),
    .mode_dec(mode_dec),
    .wait_dec(wait_dec),
    .better(better)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      task_priorities <= PRIO_RESET;
      for (int i = 0; i < NUM_TASKS; i++) begin
        task_mode[i] <= MODE_READY;
        wait_left[i] <= '0;
      end
      running_now     <= ID_NONE;
      ticks_seen      <= '0;
      best            <= BEST_INIT;
      pick            <= ID_IDLE;
      preempt         <= 1'b0;
      run_was_running <= 1'b0;
      sw              <= 1'b0;
      err             <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        task_priorities <= cfg_wr_data;
      end
      unique case (ctrl.st)
        S_IDLE: begin
          if (in_fire) begin
            best            <= BEST_INIT;
            pick            <= ID_IDLE;
            run_was_running <= 1'b0;
            preempt         <= (op_in == OP_TICK);
            sw              <= 1'b0;
            err             <= 1'b0;
            unique case (op_in)
              OP_START: begin
                ticks_seen  <= '0;
                running_now <= ID_NONE;
              end
              OP_TICK: ticks_seen <= ticks_seen + CNT_W'(1);
              OP_DELAY: begin
                if (run_valid) begin
                  task_mode[run_idx] <= MODE_WAITING;
                  wait_left[run_idx] <= delay_val;
                end else begin
                  err <= 1'b1;
                end
              end
              OP_UNUSED: ;
              default: ;
            endcase
          end
        end
        S_DECR: begin
          task_mode[idx] <= mode_dec;
          wait_left[idx] <= wait_dec;
        end
        S_SCAN: begin
          if (better) begin
            best <= ID_W'(prio_cur);
            pick <= ID_W'(idx);
          end
          if (ID_W'(idx) == running_now) begin
            run_was_running <= (task_mode[idx] == MODE_RUNNING);
          end
        end
        S_APPLY: begin
          if (pick != running_now) begin
            sw <= 1'b1;
            if (preempt && run_valid && run_was_running) begin
              task_mode[run_idx] <= MODE_READY;
            end
            running_now <= pick;
            if (pick < NUM_ID) begin
              task_mode[pick[IW-1:0]] <= MODE_RUNNING;
            end
          end
        end
        S_DONE: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      run_task      <= running_now;
      switch_needed <= sw;
      tick_count    <= ticks_seen;
      request_error <= err;
    end
  end

`ifndef SYNTH
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in progress");

  a_running_id_legal: assert property (@(posedge clk) disable iff (rst)
    running_now < NUM_ID || running_now == ID_IDLE || running_now == ID_NONE)
    else $error("running task id out of range");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ctrl.st == S_DONE))
    else $error("result presented without finishing an item");

  a_running_mode: assert property (@(posedge clk) disable iff (rst)
    ctrl.st == S_IDLE && running_now < NUM_ID |-> task_mode[run_idx] == MODE_RUNNING)
    else $error("running task not in running mode");
`endif

endmodule

>>> tb/sv/sched_check.sv
module sched_check
  import fps_pkg::*;
#(
  parameter int NUM_TASKS = 3
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [1:0]       op,
  input  logic [CNT_W-1:0] delay_ticks,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [ID_W-1:0]  run_task,
  input  logic             switch_needed,
  input  logic [CNT_W-1:0] tick_count,
  input  logic             request_error,
  output int               pending,
  output int               fail_count
);

  typedef struct packed {
    logic [ID_W-1:0]  run_task;
    logic             sw;
    logic [CNT_W-1:0] ticks;
    logic             err;
  } sched_result_t;

  mode_t            task_mode_m [NUM_TASKS];
  logic [CNT_W-1:0] wait_cnt [NUM_TASKS];
  logic [ID_W-1:0]  cur_task;
  logic [CNT_W-1:0] tick_total;
  logic [CFG_W-1:0] prio_cfg;
  sched_result_t    expected_picks [$];

  initial begin
    pending = 0;
    fail_count = 0;
  end

  function automatic logic [PRIO_W-1:0] prio_of_task(int i);
    return prio_cfg[PRIO_W*i +: PRIO_W];
  endfunction

  // choose the best non-waiting task, idle when none; 1 when the running task changed
  function automatic logic pick_and_switch(logic preempt);
    logic [ID_W-1:0] pick;
    logic [ID_W-1:0] best;
    pick = ID_IDLE;
    best = BEST_INIT;
    for (int i = 0; i < NUM_TASKS; i++) begin
      if (task_mode_m[i] != MODE_WAITING && {1'b0, prio_of_task(i)} < best) begin
        best = {1'b0, prio_of_task(i)};
        pick = ID_W'(i);
      end
    end
    if (pick == cur_task) return 1'b0;
    if (preempt && cur_task < NUM_TASKS) begin
      if (task_mode_m[cur_task] == MODE_RUNNING) task_mode_m[cur_task] = MODE_READY;
    end
    cur_task = pick;
    if (pick < NUM_TASKS) task_mode_m[pick] = MODE_RUNNING;
    return 1'b1;
  endfunction

  function automatic sched_result_t next_schedule(op_t code, logic [CNT_W-1:0] d);
    sched_result_t r;
    r = '0;
    case (code)
      OP_START: begin
        tick_total = '0;
        cur_task = ID_NONE;
      end
      OP_TICK: begin
        tick_total = tick_total + 1'b1;
        for (int i = 0; i < NUM_TASKS; i++) begin
          if (task_mode_m[i] == MODE_WAITING) begin
            if (wait_cnt[i] <= 1) begin
              wait_cnt[i] = '0;
              task_mode_m[i] = MODE_READY;
            end else begin
              wait_cnt[i] = wait_cnt[i] - 1'b1;
            end
          end
        end
        r.sw = pick_and_switch(1'b1);
      end
      OP_DELAY: begin
        if (cur_task < NUM_TASKS) begin
          task_mode_m[cur_task] = MODE_WAITING;
          wait_cnt[cur_task] = (d == '0) ? CNT_W'(1) : d;
          r.sw = pick_and_switch(1'b0);
        end else begin
          r.err = 1'b1;
        end
      end
      default: ;
    endcase
    r.run_task = cur_task;
    r.ticks = tick_total;
    return r;
  endfunction

  function automatic void check_field(string name, logic [CNT_W-1:0] exp_v,
                                      logic [CNT_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t %s expected %0d actual %0d", $time, name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    sched_result_t e;
    if (rst) begin
      for (int i = 0; i < NUM_TASKS; i++) begin
        task_mode_m[i] = MODE_READY;
        wait_cnt[i] = '0;
      end
      cur_task = ID_NONE;
      tick_total = '0;
      prio_cfg = PRIO_RESET;
      expected_picks.delete();
    end else begin
      if (cfg_wr_en) prio_cfg = cfg_wr_data;
      if (out_valid && out_ready) begin
        if (expected_picks.size() == 0) begin
          $display("%0t unexpected result transfer, expected none actual run_task %0d",
                   $time, run_task);
          fail_count++;
        end else begin
          e = expected_picks.pop_front();
          check_field("run_task", CNT_W'(e.run_task), CNT_W'(run_task));
          check_field("switch_needed", CNT_W'(e.sw), CNT_W'(switch_needed));
          check_field("tick_count", e.ticks, tick_count);
          check_field("request_error", CNT_W'(e.err), CNT_W'(request_error));
        end
      end
      if (in_valid && in_ready) expected_picks.push_back(next_schedule(op_t'(op), delay_ticks));
    end
    pending <= expected_picks.size();
  end

endmodule

>>> tb/sv/tb.sv
module tb;
  import fps_pkg::*;

  localparam int NUM_TASKS = 3;
  localparam int LIMIT = 400000;
  localparam int HOLD_CYCLES = 250;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 240;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [1:0]       op = OP_UNUSED;
  logic [CNT_W-1:0] delay_ticks = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [ID_W-1:0]  run_task;
  logic             switch_needed;
  logic [CNT_W-1:0] tick_count;
  logic             request_error;

  int pending;
  int fail_count;
  int cycles = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  logic [CFG_W-1:0] prio_sets [PHASES];

  always #6 clk = ~clk;

  fixed_priority_task_scheduler_unit #(.NUM_TASKS(NUM_TASKS)) dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .delay_ticks(delay_ticks),
    .out_valid(out_valid), .out_ready(out_ready),
    .run_task(run_task), .switch_needed(switch_needed),
    .tick_count(tick_count), .request_error(request_error)
  );

  sched_check #(.NUM_TASKS(NUM_TASKS)) chk (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .delay_ticks(delay_ticks),
    .out_valid(out_valid), .out_ready(out_ready),
    .run_task(run_task), .switch_needed(switch_needed),
    .tick_count(tick_count), .request_error(request_error),
    .pending(pending), .fail_count(fail_count)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= quiet || ($urandom_range(99) >= 16);
      end
    end
  end

  task automatic send_item(op_t code, logic [CNT_W-1:0] d);
    int gap;
    gap = 0;
    while (!quiet && $urandom_range(99) < 16) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= code;
    delay_ticks <= d;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_prio(logic [CFG_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_item(bit allow_park);
    int r;
    int q;
    logic [CNT_W-1:0] d;
    r = $urandom_range(99);
    q = $urandom_range(99);
    if (r < 6) begin
      send_item(OP_START, $urandom());
      // nothing runs right after a start, so a full-range delay is rejected
      if (q < 40) send_item(OP_DELAY, $urandom());
    end else if (r < 10) begin
      send_item(OP_UNUSED, $urandom());
    end else if (r < 55) begin
      send_item(OP_TICK, $urandom());
    end else begin
      if (q < 60) d = $urandom_range(3);
      else if (q < 90) d = $urandom_range(12, 4);
      else if (allow_park && q == 99) d = $urandom();
      else d = $urandom_range(40, 13);
      send_item(OP_DELAY, d);
    end
  endtask

  initial begin
    prio_sets[0] = '0;
    prio_sets[1] = '1;
    prio_sets[2] = CFG_W'($urandom());
    prio_sets[3] = {12'd0, 3'd1, 3'd2, 3'd4};
    prio_sets[4] = CFG_W'($urandom());
    prio_sets[5] = PRIO_RESET;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_prio(PRIO_RESET);

    send_item(OP_DELAY, 32'd5);
    send_item(OP_UNUSED, 32'hFFFF_FFFF);
    send_item(OP_TICK, 32'd0);
    send_item(OP_DELAY, 32'd0);
    send_item(OP_TICK, 32'd0);
    send_item(OP_DELAY, 32'd2);
    send_item(OP_DELAY, 32'd1);
    send_item(OP_DELAY, 32'd3);
    send_item(OP_DELAY, 32'hFFFF_FFFF);
    send_item(OP_TICK, 32'hFFFF_FFFF);
    send_item(OP_TICK, 32'd0);
    send_item(OP_TICK, 32'd0);
    send_item(OP_TICK, 32'd0);
    send_item(OP_START, 32'hFFFF_FFFF);
    send_item(OP_UNUSED, 32'd0);
    send_item(OP_DELAY, 32'hAAAA_AAAA);
    send_item(OP_DELAY, 32'h5555_5555);
    send_item(OP_TICK, 32'd0);
    send_item(OP_DELAY, 32'd1);
    send_item(OP_START, 32'd0);
    send_item(OP_TICK, 32'd0);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      write_prio(prio_sets[p]);
      quiet = (p == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 1 && n == 40) hold_req = 1'b1;
        random_item(p == PHASES - 1);
      end
      settle();
    end
    quiet = 1'b0;

    @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
